// File: src/fepa_pkg.sv
// ----------------------------------------------------------------------------
// fepa_pkg
// Shared types and constants for the free extent page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fepa_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int PAGE_BITS   = 20;
  localparam int CNT_BITS    = PAGE_BITS + 1;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int OCC_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [CNT_BITS-1:0] COUNT_MAX = {CNT_BITS{1'b1}};

  typedef enum logic [0:0] {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_LOST  = 2'd2
  } status_t;

  typedef struct packed {
    func_t                func;
    logic [PAGE_BITS-1:0] start_page;
    logic [CNT_BITS-1:0]  num_pages;
  } in_word_t;

  typedef struct packed {
    status_t              status;
    logic [PAGE_BITS-1:0] granted_page;
    logic [OCC_W-1:0]     entries_in_use;
    logic [OCC_W-1:0]     peak_entries;
    logic [31:0]          lost_pages;
  } out_word_t;

  typedef struct packed {
    logic [PAGE_BITS-1:0] start;
    logic [CNT_BITS-1:0]  count;
  } extent_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_ROT  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_INS  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] pos;
    extent_t          new_ext;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_WALK = 2'd1,
    S_EDIT = 2'd2,
    S_DONE = 2'd3
  } state_t;

endpackage

`default_nettype wire

// File: src/fepa_cell.sv
// ----------------------------------------------------------------------------
// fepa_cell
// One extent slot; rotates, closes a gap or opens a gap with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module fepa_cell
  import fepa_pkg::*;
(
  input  wire logic             clk,
  input  wire cell_ctl_t        ctl,
  input  wire logic [IDX_W-1:0] my_idx,
  input  wire extent_t          nxt_ext,
  input  wire extent_t          prv_ext,
  output extent_t               ext
);

  extent_t ext_r;
  extent_t ext_nxt;

  always_comb begin
    ext_nxt = ext_r;
    unique case (ctl.op)
      CELL_HOLD: ext_nxt = ext_r;
      CELL_ROT:  ext_nxt = nxt_ext;
      CELL_DEL: begin
        if (my_idx >= ctl.pos) ext_nxt = nxt_ext;
      end
      CELL_INS: begin
        if (my_idx > ctl.pos) ext_nxt = prv_ext;
        else if (my_idx == ctl.pos) ext_nxt = ctl.new_ext;
      end
      default: ext_nxt = ext_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ext_r <= ext_nxt;
  end

  assign ext = ext_r;

endmodule

`default_nettype wire

// File: src/fepa_chain.sv
// ----------------------------------------------------------------------------
// fepa_chain
// Row of extent cells; the head is cell 0, the tail is fed from outside.
// ----------------------------------------------------------------------------
`default_nettype none

module fepa_chain
  import fepa_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire extent_t   tail_ext,
  output extent_t        head_ext
);

  extent_t cell_ext [TABLE_DEPTH];

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    extent_t nxt_in;
    extent_t prv_in;

    if (k == TABLE_DEPTH - 1) begin : g_last
      assign nxt_in = tail_ext;
    end else begin : g_mid
      assign nxt_in = cell_ext[k+1];
    end

    if (k == 0) begin : g_first
      assign prv_in = ctl.new_ext;
    end else begin : g_rest
      assign prv_in = cell_ext[k-1];
    end

    fepa_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .my_idx  (IDX_W'(k)),
      .nxt_ext (nxt_in),
      .prv_ext (prv_in),
      .ext     (cell_ext[k])
    );
  end

  assign head_ext = cell_ext[0];

endmodule

`default_nettype wire

// File: src/free_extent_page_allocator.sv
// ----------------------------------------------------------------------------
// free_extent_page_allocator
// First-fit page allocator over a sorted table of free extents, with merging.
// ----------------------------------------------------------------------------
//  Channel | Ports                         | Direction
//  in      | in_valid, in_stall, in_word   | request word in
//  out     | out_valid, out_stall, out_word| result word out
//
//  Each request passes through an accept state, a walk that rotates the extent
//  ring once past the head through a one-slot lag register, an edit state that
//  inserts or deletes a slot, and a done state that loads the result register.
//  One request is in work at a time; in_stall is high while it is.
//  A result waiting under out_stall keeps the next request's result from
//  loading, and in_stall stays high until that result moves out.
//  Reset clears counters and control; the extent cells hold no reset value.
`default_nettype none

module free_extent_page_allocator
  import fepa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  state_t               state_r, state_nxt;
  logic [OCC_W-1:0]     step_r, step_nxt;
  in_word_t             req_r;
  extent_t              lag_r, lag_nxt;
  logic                 found_r, found_nxt;
  logic                 rm_r, rm_nxt;
  logic                 ins_r, ins_nxt;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  status_t              status_r, status_nxt;
  logic [PAGE_BITS-1:0] granted_r, granted_nxt;
  logic [OCC_W-1:0]     count_r, count_nxt;
  logic [OCC_W-1:0]     peak_r, peak_nxt;
  logic [31:0]          lost_r, lost_nxt;
  out_word_t            out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  cell_ctl_t            ctl;
  extent_t              tail_ext;
  extent_t              head_ext;

  logic                 live;
  logic                 at_end;
  logic [CNT_BITS+1:0]  prev_end;
  logic [CNT_BITS+1:0]  new_end;
  logic                 prev_ok;
  logic                 next_ok;
  logic [CNT_BITS+1:0]  merge_sum;
  logic [CNT_BITS+1:0]  next_sum;

  fepa_chain u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .tail_ext (tail_ext),
    .head_ext (head_ext)
  );

  assign live     = step_r < count_r;
  assign at_end   = step_r == OCC_W'(TABLE_DEPTH);
  assign prev_end = {3'b000, lag_r.start} + {2'b00, lag_r.count};
  assign new_end  = {3'b000, req_r.start_page} + {2'b00, req_r.num_pages};
  assign prev_ok  = (step_r != '0) && (prev_end == {3'b000, req_r.start_page});
  assign next_ok  = live && (new_end == {3'b000, head_ext.start});
  assign merge_sum = {2'b00, lag_r.count} + {2'b00, req_r.num_pages}
                   + (next_ok ? {2'b00, head_ext.count} : '0);
  assign next_sum  = {2'b00, head_ext.count} + {2'b00, req_r.num_pages};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_WALK;
      S_WALK: if (at_end) state_nxt = S_EDIT;
      S_EDIT: state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    step_nxt      = step_r;
    lag_nxt       = lag_r;
    found_nxt     = found_r;
    rm_nxt        = rm_r;
    ins_nxt       = ins_r;
    pos_nxt       = pos_r;
    status_nxt    = status_r;
    granted_nxt   = granted_r;
    count_nxt     = count_r;
    peak_nxt      = peak_r;
    lost_nxt      = lost_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    tail_ext      = lag_r;
    ctl.op        = CELL_HOLD;
    ctl.pos       = pos_r;
    ctl.new_ext   = '{start: req_r.start_page, count: req_r.num_pages};

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        step_nxt    = '0;
        found_nxt   = 1'b0;
        rm_nxt      = 1'b0;
        ins_nxt     = 1'b0;
        status_nxt  = ST_OK;
        granted_nxt = '0;
      end
      S_WALK: begin
        // The head slot moves into the lag register, the lag slot to the tail.
        ctl.op   = CELL_ROT;
        lag_nxt  = head_ext;
        step_nxt = step_r + 1'b1;
        if (req_r.func == FN_ALLOC) begin
          if (!found_r && live && head_ext.count >= req_r.num_pages) begin
            found_nxt     = 1'b1;
            granted_nxt   = head_ext.start;
            lag_nxt.start = head_ext.start + req_r.num_pages[PAGE_BITS-1:0];
            lag_nxt.count = head_ext.count - req_r.num_pages;
            rm_nxt        = head_ext.count == req_r.num_pages;
            pos_nxt       = step_r[IDX_W-1:0];
          end
        end else if (!found_r && (step_r == count_r ||
                                  (live && head_ext.start > req_r.start_page))) begin
          found_nxt = 1'b1;
          pos_nxt   = step_r[IDX_W-1:0];
          if (prev_ok) begin
            tail_ext.count = (merge_sum > {2'b00, COUNT_MAX}) ? COUNT_MAX
                                                              : merge_sum[CNT_BITS-1:0];
            rm_nxt = next_ok;
          end else if (next_ok) begin
            lag_nxt.start = req_r.start_page;
            lag_nxt.count = (next_sum > {2'b00, COUNT_MAX}) ? COUNT_MAX
                                                            : next_sum[CNT_BITS-1:0];
          end else if (count_r != OCC_W'(TABLE_DEPTH)) begin
            ins_nxt = 1'b1;
          end else begin
            status_nxt = ST_LOST;
            lost_nxt   = lost_r + 32'(req_r.num_pages);
          end
        end
      end
      S_EDIT: begin
        if (rm_r) begin
          ctl.op    = CELL_DEL;
          count_nxt = count_r - 1'b1;
        end else if (ins_r) begin
          ctl.op    = CELL_INS;
          count_nxt = count_r + 1'b1;
          if (peak_r < count_nxt) peak_nxt = count_nxt;
        end
        if (req_r.func == FN_ALLOC && !found_r) status_nxt = ST_NOFIT;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_nxt.status         = status_r;
          out_nxt.granted_page   = granted_r;
          out_nxt.entries_in_use = count_r;
          out_nxt.peak_entries   = peak_r;
          out_nxt.lost_pages     = lost_r;
        end
      end
      default: begin
        step_nxt = step_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      peak_r      <= '0;
      lost_r      <= '0;
      step_r      <= '0;
      found_r     <= 1'b0;
      rm_r        <= 1'b0;
      ins_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      peak_r      <= peak_nxt;
      lost_r      <= lost_nxt;
      step_r      <= step_nxt;
      found_r     <= found_nxt;
      rm_r        <= rm_nxt;
      ins_r       <= ins_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) req_r <= in_word;
    lag_r     <= lag_nxt;
    pos_r     <= pos_nxt;
    status_r  <= status_nxt;
    granted_r <= granted_nxt;
    out_r     <= out_nxt;
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

`default_nettype wire
